>>> hw/rtl/obb_pkg.sv
// Shared types and constants for the oriented bounding box block.
// No dependencies; every other file refers to it by scoped names.

package obb_pkg;

  // Configuration register indexes (word address bit 2)
  localparam logic REG_MIN_WIDTH  = 1'b0;
  localparam logic REG_MIN_LENGTH = 1'b1;

  // Configuration register reset values, 1/256 m
  localparam logic [15:0] MIN_WIDTH_RST  = 16'd512;
  localparam logic [15:0] MIN_LENGTH_RST = 16'd1024;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ROUND,
    S_UPD,
    S_GROW,
    S_CENTER,
    S_FINAL
  } back_state_t;

endpackage

>>> hw/rtl/obb_queue.sv
// Short register queue between the point front end and the box back end.
// Depends on obb_pkg for the depth and the status struct.

module obb_queue #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   pop_data,
  output obb_pkg::q_stat_t   stat
);

  localparam int DEPTH = obb_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

>>> hw/rtl/obb_front.sv
// Front end: accepts points, latches the cloud's trig and angle on its
// first point and pushes each point with them into the queue. Uses obb_pkg.

module obb_front #(
  parameter int COORD_BITS     = 24,
  parameter int TRIG_FRAC_BITS = 14,
  localparam int TB            = TRIG_FRAC_BITS + 2,
  localparam int ITEM_W        = 2 * COORD_BITS + 2 * TB + 17
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic [15:0]                  angle_code,
  input  logic signed [TB-1:0]         cos_value,
  input  logic signed [TB-1:0]         sin_value,
  input  logic                         last_point,
  input  obb_pkg::q_stat_t             qstat,
  output logic                         q_push,
  output logic [ITEM_W-1:0]            q_data
);

  logic                 in_cloud_r, in_cloud_nxt;
  logic signed [TB-1:0] held_cos_r, held_sin_r;
  logic [15:0]          held_angle_r;
  logic signed [TB-1:0] use_cos, use_sin;
  logic [15:0]          use_angle;

  assign in_tready = !qstat.full;
  assign q_push    = in_tvalid && in_tready;

  // Take trig from the first point of a cloud, else from the latch
  assign use_cos   = in_cloud_r ? held_cos_r   : cos_value;
  assign use_sin   = in_cloud_r ? held_sin_r   : sin_value;
  assign use_angle = in_cloud_r ? held_angle_r : angle_code;

  assign in_cloud_nxt = q_push ? !last_point : in_cloud_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cloud_r <= 1'b0;
    end else begin
      in_cloud_r <= in_cloud_nxt;
    end
  end

  // Latch trig on the opening transfer of a cloud
  always_ff @(posedge clk) begin
    if (q_push && !in_cloud_r) begin
      held_cos_r   <= cos_value;
      held_sin_r   <= sin_value;
      held_angle_r <= angle_code;
    end
  end

  assign q_data = {last_point, use_angle, use_sin, use_cos, point_y, point_x};

endmodule

>>> hw/rtl/obb_back.sv
// Back end: rotates queued points on one shared multiplier, tracks the
// extremes, then grows, centers and un-rotates the box. Uses obb_pkg.

module obb_back #(
  parameter int COORD_BITS     = 24,
  parameter int TRIG_FRAC_BITS = 14,
  localparam int TB            = TRIG_FRAC_BITS + 2,
  localparam int ITEM_W        = 2 * COORD_BITS + 2 * TB + 17,
  localparam int OUT_RAW       = 4 * COORD_BITS + 18,
  localparam int OUT_DATA_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  obb_pkg::q_stat_t      qstat,
  input  logic [ITEM_W-1:0]     q_data,
  output logic                  q_pop,
  input  logic [15:0]           min_box_width,
  input  logic [15:0]           min_box_length,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int C    = COORD_BITS;
  localparam int T    = TRIG_FRAC_BITS;
  localparam int ROT  = C + 2;
  localparam int GW   = ((ROT > 17) ? ROT : 17) + 1;
  localparam int PW   = GW + TB;
  localparam int AW   = PW + 2;
  localparam int SW   = AW - T;
  localparam int OFS_Y   = C;
  localparam int OFS_COS = 2 * C;
  localparam int OFS_SIN = 2 * C + TB;
  localparam int OFS_ANG = 2 * C + 2 * TB;

  localparam logic signed [AW-1:0] RND = {{(AW - T){1'b0}}, 1'b1, {(T - 1){1'b0}}};
  localparam logic signed [SW-1:0] ROT_HI = {{(SW - ROT + 1){1'b0}}, {(ROT - 1){1'b1}}};
  localparam logic signed [SW-1:0] ROT_LO = {{(SW - ROT + 1){1'b1}}, {(ROT - 1){1'b0}}};
  localparam logic signed [SW-1:0] CRD_HI = {{(SW - C + 1){1'b0}}, {(C - 1){1'b1}}};
  localparam logic signed [SW-1:0] CRD_LO = {{(SW - C + 1){1'b1}}, {(C - 1){1'b0}}};
  localparam logic signed [ROT-1:0] EXT_HI = {1'b0, {(ROT - 1){1'b1}}};
  localparam logic signed [ROT-1:0] EXT_LO = {1'b1, {(ROT - 1){1'b0}}};
  localparam logic signed [GW:0] LEN_TOP = {{(GW - C){1'b0}}, {(C + 1){1'b1}}};

  // Round half up, then floor shift by the fraction bits
  function automatic logic signed [SW-1:0] round_q(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    t = v + RND;
    return t[AW-1:T];
  endfunction

  function automatic logic signed [SW-1:0] clip(input logic signed [SW-1:0] v,
                                                input logic signed [SW-1:0] hi,
                                                input logic signed [SW-1:0] lo);
    logic signed [SW-1:0] r;
    r = v;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end
    return r;
  endfunction

  // Clamp an extent to its minimum and to the output range
  function automatic logic [C:0] extent(input logic signed [GW-1:0] lo,
                                        input logic signed [GW-1:0] hi,
                                        input logic [15:0] minimum);
    logic signed [GW:0] d;
    logic signed [GW:0] m;
    d = {hi[GW-1], hi} - {lo[GW-1], lo};
    m = {{(GW + 1 - 16){1'b0}}, minimum};
    if (d < m) begin
      d = m;
    end
    if (d > LEN_TOP) begin
      d = LEN_TOP;
    end
    return d[C:0];
  endfunction

  obb_pkg::back_state_t state_r, state_nxt;
  logic [2:0]           step_r, step_nxt;
  logic                 unrot_r, unrot_nxt;
  logic [ITEM_W-1:0]    item_r;
  logic                 out_load;

  logic signed [C-1:0]   pt_x, pt_y;
  logic signed [TB-1:0]  trig_c, trig_s;
  logic                  pt_last;

  logic signed [GW-1:0]  mul_a;
  logic signed [TB-1:0]  mul_b;
  logic signed [PW-1:0]  prod_r;
  logic signed [AW-1:0]  prod_ext;
  logic signed [AW-1:0]  acc_a_r, acc_b_r;

  logic signed [ROT-1:0] rx_r, ry_r;
  logic signed [ROT-1:0] mnx_r, mxx_r, mny_r, mxy_r;
  logic signed [GW-1:0]  gmnx_r, gmxx_r, gmny_r, gmxy_r;
  logic signed [GW-1:0]  gmnx, gmxx, gmny, gmxy;
  logic signed [GW-1:0]  cxr_r, cyr_r;
  logic signed [GW:0]    sum_x, sum_y;
  logic [C:0]            wd_r, ln_r;
  logic signed [SW-1:0]  rnd_a, rnd_b;
  logic signed [SW-1:0]  rx_w, ry_w;
  logic signed [SW-1:0]  cx_w, cy_w;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign pt_x    = item_r[C-1:0];
  assign pt_y    = item_r[OFS_Y +: C];
  assign trig_c  = item_r[OFS_COS +: TB];
  assign trig_s  = item_r[OFS_SIN +: TB];
  assign pt_last = item_r[ITEM_W-1];

  assign q_pop    = (state_r == obb_pkg::S_IDLE) && !qstat.empty;
  assign out_load = (state_r == obb_pkg::S_FINAL) && (!out_valid_r || out_tready);

  // Next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unrot_nxt = unrot_r;
    case (state_r)
      obb_pkg::S_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = obb_pkg::S_MUL;
          step_nxt  = '0;
          unrot_nxt = 1'b0;
        end
      end
      obb_pkg::S_MUL: begin
        if (step_r == 3'd4) begin
          state_nxt = unrot_r ? obb_pkg::S_FINAL : obb_pkg::S_ROUND;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      obb_pkg::S_ROUND: state_nxt = obb_pkg::S_UPD;
      obb_pkg::S_UPD:   state_nxt = pt_last ? obb_pkg::S_GROW : obb_pkg::S_IDLE;
      obb_pkg::S_GROW:  state_nxt = obb_pkg::S_CENTER;
      obb_pkg::S_CENTER: begin
        state_nxt = obb_pkg::S_MUL;
        step_nxt  = '0;
        unrot_nxt = 1'b1;
      end
      obb_pkg::S_FINAL: begin
        if (out_load) begin
          state_nxt = obb_pkg::S_IDLE;
        end
      end
      default: state_nxt = obb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obb_pkg::S_IDLE;
      step_r  <= '0;
      unrot_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      unrot_r <= unrot_nxt;
    end
  end

  // Select multiplier operands for each step
  always_comb begin
    mul_a = {{(GW - C){pt_x[C-1]}}, pt_x};
    mul_b = trig_c;
    case (step_r)
      3'd1: begin
        mul_a = unrot_r ? cyr_r : {{(GW - C){pt_y[C-1]}}, pt_y};
        mul_b = trig_s;
      end
      3'd2: begin
        mul_a = unrot_r ? cxr_r : {{(GW - C){pt_y[C-1]}}, pt_y};
        mul_b = unrot_r ? trig_s : trig_c;
      end
      3'd3: begin
        mul_a = unrot_r ? cyr_r : {{(GW - C){pt_x[C-1]}}, pt_x};
        mul_b = unrot_r ? trig_c : trig_s;
      end
      default: begin
        mul_a = unrot_r ? cxr_r : {{(GW - C){pt_x[C-1]}}, pt_x};
        mul_b = trig_c;
      end
    endcase
  end

  assign prod_ext = {{(AW - PW){prod_r[PW-1]}}, prod_r};

  // Grow the box away from the origin to its minimum size
  always_comb begin
    gmnx = {{(GW - ROT){mnx_r[ROT-1]}}, mnx_r};
    gmxx = {{(GW - ROT){mxx_r[ROT-1]}}, mxx_r};
    gmny = {{(GW - ROT){mny_r[ROT-1]}}, mny_r};
    gmxy = {{(GW - ROT){mxy_r[ROT-1]}}, mxy_r};
    if (gmxy < 0) begin
      if (gmxy - {{(GW - 16){1'b0}}, min_box_width} < gmny) begin
        gmny = gmxy - {{(GW - 16){1'b0}}, min_box_width};
      end
    end else if (gmny > 0) begin
      if (gmny + {{(GW - 16){1'b0}}, min_box_width} > gmxy) begin
        gmxy = gmny + {{(GW - 16){1'b0}}, min_box_width};
      end
    end
    if (gmxx < 0) begin
      if (gmxx - {{(GW - 16){1'b0}}, min_box_length} < gmnx) begin
        gmnx = gmxx - {{(GW - 16){1'b0}}, min_box_length};
      end
    end else if (gmnx > 0) begin
      if (gmnx + {{(GW - 16){1'b0}}, min_box_length} > gmxx) begin
        gmxx = gmnx + {{(GW - 16){1'b0}}, min_box_length};
      end
    end
  end

  assign sum_x = {gmnx_r[GW-1], gmnx_r} + {gmxx_r[GW-1], gmxx_r};
  assign sum_y = {gmny_r[GW-1], gmny_r} + {gmxy_r[GW-1], gmxy_r};
  assign rnd_a = round_q(acc_a_r);
  assign rnd_b = round_q(acc_b_r);
  assign rx_w  = clip(rnd_a, ROT_HI, ROT_LO);
  assign ry_w  = clip(rnd_b, ROT_HI, ROT_LO);
  assign cx_w  = clip(rnd_a, CRD_HI, CRD_LO);
  assign cy_w  = clip(rnd_b, CRD_HI, CRD_LO);

  // Multiply and accumulate the two dot products
  always_ff @(posedge clk) begin
    if (state_r == obb_pkg::S_MUL) begin
      prod_r <= mul_a * mul_b;
      case (step_r)
        3'd1:    acc_a_r <= prod_ext;
        3'd2:    acc_a_r <= unrot_r ? acc_a_r - prod_ext : acc_a_r + prod_ext;
        3'd3:    acc_b_r <= prod_ext;
        3'd4:    acc_b_r <= unrot_r ? acc_b_r + prod_ext : acc_b_r - prod_ext;
        default: acc_a_r <= acc_a_r;
      endcase
    end
  end

  // Hold the popped point
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_data;
    end
  end

  // Round and clip the rotated point
  always_ff @(posedge clk) begin
    if (state_r == obb_pkg::S_ROUND) begin
      rx_r <= rx_w[ROT-1:0];
      ry_r <= ry_w[ROT-1:0];
    end
  end

  // Track extremes; drop them back to reset values when the box is grown
  always_ff @(posedge clk) begin
    if (!rst_n || state_r == obb_pkg::S_GROW) begin
      mnx_r <= EXT_HI;
      mny_r <= EXT_HI;
      mxx_r <= EXT_LO;
      mxy_r <= EXT_LO;
    end else if (state_r == obb_pkg::S_UPD) begin
      if (rx_r < mnx_r) mnx_r <= rx_r;
      if (rx_r > mxx_r) mxx_r <= rx_r;
      if (ry_r < mny_r) mny_r <= ry_r;
      if (ry_r > mxy_r) mxy_r <= ry_r;
    end
  end

  // Grown box, then its center and extents
  always_ff @(posedge clk) begin
    if (state_r == obb_pkg::S_GROW) begin
      gmnx_r <= gmnx;
      gmxx_r <= gmxx;
      gmny_r <= gmny;
      gmxy_r <= gmxy;
    end
    if (state_r == obb_pkg::S_CENTER) begin
      cxr_r <= sum_x[GW:1];
      cyr_r <= sum_y[GW:1];
      wd_r  <= extent(gmny_r, gmxy_r, min_box_width);
      ln_r  <= extent(gmnx_r, gmxx_r, min_box_length);
    end
  end

  // Output register: a result waits here while the next points go on
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_DATA_W'({ln_r, wd_r, item_r[OFS_ANG +: 16],
                                 cy_w[C-1:0], cx_w[C-1:0]});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/oriented_min_size_bounding_box.sv
// The back end handles one point at a time on its shared multiplier and pops
// the next only when through with the last: pop, five multiply steps, round
// and update; a last point adds grow, center, five more multiply steps and a load.
// Points queue two deep ahead of the back end; a result waits in the output register.
// Reset (synchronous, rst_n low) closes any open cloud and restores register defaults.
// Top level: configuration registers, front end, queue and back end; uses obb_pkg.

module oriented_min_size_bounding_box #(
  parameter int COORD_BITS     = 24,
  parameter int TRIG_FRAC_BITS = 14,
  localparam int TB            = TRIG_FRAC_BITS + 2,
  localparam int IN_RAW        = 2 * COORD_BITS + 16 + 2 * TB,
  localparam int IN_DATA_W     = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW       = 4 * COORD_BITS + 18,
  localparam int OUT_DATA_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Point channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata, low bit up: point_x, point_y, angle_code, cos_value, sin_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  // Box channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata, low bit up: center_x, center_y, yaw_code, box_width, box_length
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int C      = COORD_BITS;
  localparam int ITEM_W = 2 * C + 2 * TB + 17;

  logic [15:0]       min_width_r, min_length_r;
  logic              cfg_wr;
  logic              q_push, q_pop;
  logic [ITEM_W-1:0] q_wdata, q_rdata;
  obb_pkg::q_stat_t  qstat;

  // Configuration writes complete in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_width_r  <= obb_pkg::MIN_WIDTH_RST;
      min_length_r <= obb_pkg::MIN_LENGTH_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        obb_pkg::REG_MIN_WIDTH:  min_width_r  <= cfg_pwdata[15:0];
        obb_pkg::REG_MIN_LENGTH: min_length_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_paddr[2])
      obb_pkg::REG_MIN_WIDTH:  cfg_prdata = {16'd0, min_width_r};
      obb_pkg::REG_MIN_LENGTH: cfg_prdata = {16'd0, min_length_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  obb_front #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .point_x    (in_tdata[C-1:0]),
    .point_y    (in_tdata[2*C-1:C]),
    .angle_code (in_tdata[2*C+15:2*C]),
    .cos_value  (in_tdata[2*C+16 +: TB]),
    .sin_value  (in_tdata[2*C+16+TB +: TB]),
    .last_point (in_tlast),
    .qstat      (qstat),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  obb_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (qstat)
  );

  obb_back #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qstat          (qstat),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .min_box_width  (min_width_r),
    .min_box_length (min_length_r),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata)
  );

endmodule
